@@ src/assert_macros.svh @@
// Assertion helpers shared by the block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside of reset.
`define ISM_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("ism check failed");

// An implication that must hold at every clock edge outside of reset.
`define ISM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ism check failed");

`endif

@@ src/ism_pkg.sv @@
package ism_pkg;
	localparam int MAX_SPANS   = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(MAX_SPANS + 1);

	typedef logic signed [VALUE_WIDTH-1:0] value_t;

	typedef struct packed {
		value_t lo;
		value_t hi;
	} span_t;

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_START = 3'b010,
		ST_SWEEP = 3'b100
	} state_t;

	typedef struct packed {
		logic insert;
		logic set_ovf;
		logic take_head;
		logic merge;
		logic emit;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic accept;
		logic last;
		logic full;
		logic head_valid;
		logic head_overlaps;
		logic out_free;
	} sts_t;

	// Ordering by start, ties by end.
	function automatic logic span_before(span_t a, span_t b);
		logic r;
		if (a.lo != b.lo) begin
			r = a.lo < b.lo;
		end else begin
			r = a.hi < b.hi;
		end
		return r;
	endfunction
endpackage

@@ src/ism_if.sv @@
interface span_if;
	import ism_pkg::*;
	logic   valid;
	logic   ready;
	logic [31:0] span_start;
	logic [31:0] span_end;
	logic   set_last;
	modport source (output valid, output span_start, output span_end, output set_last,
		input ready);
	modport sink (input valid, input span_start, input span_end, input set_last,
		output ready);
endinterface

interface merge_if;
	logic   valid;
	logic   ready;
	logic [31:0] merged_start;
	logic [31:0] merged_end;
	logic   merged_last;
	logic   dropped_flag;
	modport source (output valid, output merged_start, output merged_end,
		output merged_last, output dropped_flag, input ready);
	modport sink (input valid, input merged_start, input merged_end,
		input merged_last, input dropped_flag, output ready);
endinterface

@@ src/ism_ctrl.sv @@
`include "assert_macros.svh"
module ism_ctrl import ism_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  sts_t   sts,
	output cmd_t   cmd,
	output logic   in_ready
);
	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (sts.accept) begin
					cmd.insert  = !sts.full;
					cmd.set_ovf = sts.full;
					if (sts.last) begin
						state_n = ST_START;
					end
				end
			end
			ST_START: begin
				cmd.take_head = 1'b1;
				state_n = ST_SWEEP;
			end
			ST_SWEEP: begin
				if (sts.head_valid && sts.head_overlaps) begin
					cmd.merge = 1'b1;
				end else if (sts.head_valid) begin
					if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.take_head = 1'b1;
					end
				end else if (sts.out_free) begin
					cmd.emit   = 1'b1;
					cmd.finish = 1'b1;
					state_n = ST_LOAD;
				end
			end
			default: state_n = ST_LOAD;
		endcase
	end

	`ISM_ASSERT_IMPL(a_emit_free, cmd.emit, sts.out_free)
	`ISM_ASSERT_IMPL(a_start_follows, state_q == ST_START, $past(sts.accept && sts.last))
endmodule

@@ src/ism_dp.sv @@
`include "assert_macros.svh"
module ism_dp import ism_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [31:0] in_start,
	input  logic [31:0] in_end,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        in_last,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [31:0] out_start,
	output logic [31:0] out_end,
	output logic        out_last,
	output logic        out_drop
);
	span_t                cell_q [MAX_SPANS];
	logic [MAX_SPANS-1:0] vld_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 ovf_q;
	value_t               run_lo_q, run_hi_q;
	logic                 out_valid_q;
	value_t               out_lo_q, out_hi_q;
	logic                 out_last_q, out_drop_q;

	span_t                x;
	logic [MAX_SPANS-1:0] lt;
	span_t                ins_cell [MAX_SPANS];
	span_t                shf_cell [MAX_SPANS];

	assign x.lo = in_start[VALUE_WIDTH-1:0];
	assign x.hi = in_end[VALUE_WIDTH-1:0];

	// Each cell compares with the new interval; the chain stays sorted.
	always_comb begin
		for (int i = 0; i < MAX_SPANS; i++) begin
			lt[i] = !vld_q[i] || span_before(x, cell_q[i]);
		end
		ins_cell[0] = lt[0] ? x : cell_q[0];
		for (int i = 1; i < MAX_SPANS; i++) begin
			if (!lt[i]) begin
				ins_cell[i] = cell_q[i];
			end else if (lt[i-1]) begin
				ins_cell[i] = cell_q[i-1];
			end else begin
				ins_cell[i] = x;
			end
		end
		for (int i = 0; i < MAX_SPANS - 1; i++) begin
			shf_cell[i] = cell_q[i+1];
		end
		shf_cell[MAX_SPANS-1] = cell_q[MAX_SPANS-1];
	end

	logic shift;
	assign shift = cmd.take_head || cmd.merge;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_SPANS; i++) begin
			if (cmd.insert) begin
				cell_q[i] <= ins_cell[i];
			end else if (shift) begin
				cell_q[i] <= shf_cell[i];
			end
		end
		if (cmd.take_head) begin
			run_lo_q <= cell_q[0].lo;
			run_hi_q <= cell_q[0].hi;
		end else if (cmd.merge && (cell_q[0].hi > run_hi_q)) begin
			run_hi_q <= cell_q[0].hi;
		end
		if (cmd.emit) begin
			out_lo_q   <= run_lo_q;
			out_hi_q   <= run_hi_q;
			out_last_q <= cmd.finish;
			out_drop_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.insert) begin
				vld_q <= {vld_q[MAX_SPANS-2:0], 1'b1} | vld_q;
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (shift) begin
				vld_q <= {1'b0, vld_q[MAX_SPANS-1:1]};
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.finish) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.accept        = in_valid && in_ready;
		sts.last          = in_last;
		sts.full          = (cnt_q == CNT_W'(MAX_SPANS));
		sts.head_valid    = vld_q[0];
		sts.head_overlaps = cell_q[0].lo <= run_hi_q;
		sts.out_free      = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_start = 32'(out_lo_q);
	assign out_end   = 32'(out_hi_q);
	assign out_last  = out_last_q;
	assign out_drop  = out_drop_q;

	`ISM_ASSERT(a_cnt_range, cnt_q <= CNT_W'(MAX_SPANS))
	`ISM_ASSERT(a_vld_packed, ((vld_q >> 1) & ~vld_q) == '0)
endmodule

@@ src/interval_sort_merge_top.sv @@
// Loading takes one cycle per request; the request marked last closes the set.
// After the closing request the running interval is primed from the head cell.
// The sweep merges an overlapping head or emits the running interval and moves on.
// An emit waits while the output register holds an unread span. No new request is
// taken until the sweep emits the final interval and closes the set.
// Reset (arst_n low) clears the controller, cell valid bits, count and flags.
module interval_sort_merge_top import ism_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	span_if.sink     spans,
	merge_if.source  merged
);
	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	// The controller sequences loading and the merge sweep.
	ism_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	assign spans.ready = in_ready;

	// The datapath holds the insertion-sorting cell chain, the running
	// interval and the output register.
	ism_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_start  (spans.span_start),
		.in_end    (spans.span_end),
		.in_valid  (spans.valid),
		.in_ready  (in_ready),
		.in_last   (spans.set_last),
		.out_ready (merged.ready),
		.out_valid (merged.valid),
		.out_start (merged.merged_start),
		.out_end   (merged.merged_end),
		.out_last  (merged.merged_last),
		.out_drop  (merged.dropped_flag)
	);
endmodule

@@ tb/tb_interval_sort_merge_top.sv @@
`timescale 1ns / 100ps

module tb_interval_sort_merge_top;
	import ism_pkg::*;

	typedef struct {
		logic [31:0] lo;
		logic [31:0] hi;
		logic        last;
		logic        drop;
	} merged_span_t;

	// One row of the directed table. When check_row is set, the typed-in
	// merged span is what the block's output is compared with.
	typedef struct {
		logic [31:0] lo;
		logic [31:0] hi;
		logic        last;
		logic        check_row;
		logic [31:0] want_lo;
		logic [31:0] want_hi;
	} row_t;

	logic clk;
	logic arst_n;
	span_if  spans ();
	merge_if merged ();

	interval_sort_merge_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.spans  (spans.sink),
		.merged (merged.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: the intervals of the open set, held as full 32-bit
	// signed values, and whether the set has already lost an interval.
	logic signed [31:0] pend_lo [$];
	logic signed [31:0] pend_hi [$];
	logic               pend_dropped;
	merged_span_t       merged_due [$];
	int                 error_count;
	logic               idle_enable;
	logic               hold_off;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("ERROR %0t: %s got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	// Takes in one accepted request and queues the merged spans that it closes.
	task automatic predict_merge(input logic [31:0] lo, input logic [31:0] hi,
		input logic last);
		logic signed [31:0] keys_lo [$];
		logic signed [31:0] keys_hi [$];
		logic signed [31:0] t_lo;
		logic signed [31:0] t_hi;
		logic signed [31:0] run_lo;
		logic signed [31:0] run_hi;
		merged_span_t m;
		int j;
		if (pend_lo.size() < MAX_SPANS) begin
			pend_lo.insert(pend_lo.size(), lo);
			pend_hi.insert(pend_hi.size(), hi);
		end else begin
			pend_dropped = 1'b1;
		end
		if (!last) return;
		keys_lo = pend_lo;
		keys_hi = pend_hi;
		// Insertion sort by start, ties by end.
		for (int i = 1; i < keys_lo.size(); i++) begin
			t_lo = keys_lo[i];
			t_hi = keys_hi[i];
			j = i;
			while (j > 0 && (t_lo < keys_lo[j-1] ||
				(t_lo == keys_lo[j-1] && t_hi < keys_hi[j-1]))) begin
				keys_lo[j] = keys_lo[j-1];
				keys_hi[j] = keys_hi[j-1];
				j--;
			end
			keys_lo[j] = t_lo;
			keys_hi[j] = t_hi;
		end
		run_lo = keys_lo[0];
		run_hi = keys_hi[0];
		for (int i = 1; i < keys_lo.size(); i++) begin
			if (keys_lo[i] <= run_hi) begin
				if (keys_hi[i] > run_hi) run_hi = keys_hi[i];
			end else begin
				m = '{run_lo, run_hi, 1'b0, pend_dropped};
				merged_due.insert(merged_due.size(), m);
				run_lo = keys_lo[i];
				run_hi = keys_hi[i];
			end
		end
		m = '{run_lo, run_hi, 1'b1, pend_dropped};
		merged_due.insert(merged_due.size(), m);
		pend_lo.delete();
		pend_hi.delete();
		pend_dropped = 1'b0;
	endtask

	// Drives one request at the falling edge and holds it until it is taken.
	// valid stays high across back-to-back requests.
	task automatic send_span(input logic [31:0] lo, input logic [31:0] hi,
		input logic last);
		int gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			spans.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		spans.valid      <= 1'b1;
		spans.span_start <= lo;
		spans.span_end   <= hi;
		spans.set_last   <= last;
		do @(posedge clk); while (!spans.ready);
		predict_merge(lo, hi, last);
		@(negedge clk);
	endtask

	task automatic end_requests();
		spans.valid <= 1'b0;
	endtask

	// Draws a value that is often near a neighbor or at an extreme so that
	// overlaps, touching ends and sign boundaries all come up.
	function automatic logic [31:0] pick_value(input logic [31:0] near);
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'h8000_0000;
			1: v = 32'h7fff_ffff;
			2: v = $urandom();
			3, 4: v = near + $urandom_range(0, 20) - 10;
			default: v = $urandom_range(0, 200) - 100;
		endcase
		return v;
	endfunction

	// Accepts merged spans and checks them against the oldest expectation.
	always @(posedge clk) begin
		merged_span_t w;
		if (arst_n && merged.valid && merged.ready) begin
			if (merged_due.size() == 0) begin
				report_mismatch("unexpected merged span", merged.merged_start, 'x);
			end else begin
				w = merged_due.pop_front();
				if (merged.merged_start !== w.lo)
					report_mismatch("merged_start", merged.merged_start, w.lo);
				if (merged.merged_end !== w.hi)
					report_mismatch("merged_end", merged.merged_end, w.hi);
				if (merged.merged_last !== w.last)
					report_mismatch("merged_last", 32'(merged.merged_last),
						32'(w.last));
				if (merged.dropped_flag !== w.drop)
					report_mismatch("dropped_flag", 32'(merged.dropped_flag),
						32'(w.drop));
			end
		end
	end

	// Receiver side: random stall bursts, plus a long hold-off when asked.
	initial begin
		int burst;
		merged.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				merged.ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
				merged.ready <= 1'b1;
			end else if (idle_enable && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(1, 9);
				merged.ready <= 1'b0;
				repeat (burst) @(negedge clk);
				merged.ready <= 1'b1;
			end else begin
				merged.ready <= 1'b1;
			end
		end
	end

	// Directed rows. Single-interval sets have an obvious result, so those
	// carry their answer; the rest are left to the predictor.
	row_t directed [] = '{
		'{32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1, 32'h8000_0000, 32'h7fff_ffff},
		'{32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff},
		'{32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000},
		// Reversed interval, kept as given.
		'{32'd10, 32'hffff_fff6, 1'b1, 1'b1, 32'd10, 32'hffff_fff6},
		'{32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b1, 32'hffff_ffff, 32'h0000_0000},
		// Out of order, touching, nested and disjoint intervals.
		'{32'd20, 32'd30, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'd1,  32'd5,  1'b0, 1'b0, 32'd0, 32'd0},
		'{32'd5,  32'd8,  1'b0, 1'b0, 32'd0, 32'd0},
		'{32'd2,  32'd3,  1'b0, 1'b0, 32'd0, 32'd0},
		'{32'd9,  32'd9,  1'b0, 1'b0, 32'd0, 32'd0},
		'{32'd30, 32'd25, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'hffff_fff0, 32'hffff_fff8, 1'b1, 1'b0, 32'd0, 32'd0},
		// Same start, different ends, with a reversed one inside.
		'{32'd4, 32'd7, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'd4, 32'd2, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'd4, 32'd9, 1'b1, 1'b0, 32'd0, 32'd0}
	};

	initial begin
		logic [31:0] lo;
		logic [31:0] hi;
		logic        last;
		int          set_len;
		int          wait_cycles;
		arst_n       = 1'b0;
		error_count  = 0;
		pend_dropped = 1'b0;
		idle_enable  = 1'b0;
		hold_off     = 1'b0;
		spans.valid      <= 1'b0;
		spans.span_start <= '0;
		spans.span_end   <= '0;
		spans.set_last   <= 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].check_row)
				merged_due.insert(merged_due.size(), merged_span_t'{
					directed[i].want_lo, directed[i].want_hi, 1'b1, 1'b0});
			else
				send_span(directed[i].lo, directed[i].hi, directed[i].last);
			if (directed[i].check_row) begin
				// Send without predicting twice: the typed-in answer stands in.
				spans.valid      <= 1'b1;
				spans.span_start <= directed[i].lo;
				spans.span_end   <= directed[i].hi;
				spans.set_last   <= 1'b1;
				do @(posedge clk); while (!spans.ready);
				@(negedge clk);
			end
		end

		// Overflow: a full set plus extra requests, with the closing one dropped.
		for (int i = 0; i < MAX_SPANS + 3; i++) begin
			lo = i * 3;
			send_span(lo, lo + 1, i == MAX_SPANS + 2);
		end

		// Long receiver hold-off while a big set streams in and drains.
		hold_off = 1'b1;
		for (int i = 0; i < 40; i++) begin
			lo = i * 4;
			send_span(lo, lo + $urandom_range(0, 6), i == 39);
		end

		// Random sets with idling on both sides.
		idle_enable = 1'b1;
		for (int n = 0; n < 100; n += set_len) begin
			set_len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 68)
				: $urandom_range(1, 8);
			lo = $urandom_range(0, 200) - 100;
			for (int k = 0; k < set_len; k++) begin
				lo = pick_value(lo);
				hi = ($urandom_range(0, 7) == 0) ? pick_value(lo)
					: lo + $urandom_range(0, 12);
				last = (k == set_len - 1);
				// Last part of the run: no idling.
				if (n + k > 80) idle_enable = 1'b0;
				send_span(lo, hi, last);
			end
		end
		end_requests();

		wait_cycles = 0;
		while (merged_due.size() != 0 && wait_cycles < 20000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (200) @(negedge clk);
		if (error_count == 0 && merged_due.size() == 0) begin
			$display("interval_sort_merge_top: match");
		end else begin
			$display("interval_sort_merge_top: mismatch");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("interval_sort_merge_top: mismatch");
		$finish;
	end
endmodule
